### rtl/ilxsb_pkg.sv
// shared types, constants and address helper for the xor sprite row blitter
// no dependencies; imported by ilxsb_ctrl, ilxsb_datapath and the top level
`default_nettype none

package ilxsb_pkg;

    localparam int ADDR_W     = 10;
    localparam int BANK_DEPTH = 1 << ADDR_W;
    localparam int STEP_W     = 3;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [STEP_W-1:0] step_t;

    localparam addr_t      ROW_GROUP_STRIDE = 10'h080;
    localparam addr_t      ROW_THIRD_STRIDE = 10'h028;
    localparam logic [7:0] NIB_HIGH         = 8'hF0;
    localparam logic [7:0] NIB_LOW          = 8'h0F;
    localparam step_t      LAST_STEP        = 3'd7;
    localparam addr_t      CLEAR_LAST       = 10'h3FF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic  load_item;
        logic  issue;
        step_t step;
        logic  clear_we;
        addr_t clear_addr;
    } blit_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic wb_free;
    } blit_status_t;

    // byte offset of the first byte of a screen row pair
    function automatic addr_t row_base(input logic [5:0] y);
        logic [4:0] r;
        r = y[5:1];
        return addr_t'(r[2:0]) * ROW_GROUP_STRIDE + addr_t'(r[4:3]) * ROW_THIRD_STRIDE;
    endfunction

endpackage

`default_nettype wire

### rtl/ilxsb_ctrl.sv
// controller for the xor sprite row blitter: clear sweep, item intake, step sequencing
// depends on ilxsb_pkg
`default_nettype none

module ilxsb_ctrl
    import ilxsb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire blit_status_t status,
    output blit_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;
    step_t       step_reg, step_next;
    addr_t       clr_cnt_reg, clr_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == CLEAR_LAST)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.wb_free && step_reg == LAST_STEP)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // last write must land before the next item can read
                if (status.wb_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs and counters
    always_comb
    begin
        in_ready       = 1'b0;
        cmd.load_item  = 1'b0;
        cmd.issue      = 1'b0;
        cmd.step       = step_reg;
        cmd.clear_we   = 1'b0;
        cmd.clear_addr = clr_cnt_reg;
        step_next      = step_reg;
        clr_cnt_next   = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_we = 1'b1;
                clr_cnt_next = clr_cnt_reg + addr_t'(1);
            end
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
                step_next     = '0;
            end
            ST_RUN:
            begin
                cmd.issue = status.wb_free;
                if (status.wb_free)
                    step_next = step_reg + step_t'(1);
            end
            ST_DRAIN:
            begin
                step_next = '0;
            end
            default:
            begin
                step_next = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/ilxsb_datapath.sv
// datapath for the xor sprite row blitter: item registers, two display banks,
// read-modify-write stage and output register; depends on ilxsb_pkg
`default_nettype none

module ilxsb_datapath
    import ilxsb_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire blit_cmd_t    cmd,
    output blit_status_t      status,
    input  wire logic [23:0]  in_data,
    input  wire logic         in_last,
    output logic [23:0]       out_data,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              out_last,
    output logic              out_user
);

    // item registers
    addr_t      off_a_reg;
    addr_t      off_b_reg;
    logic       first_aux_reg;
    logic [7:0] nib_reg;
    logic [7:0] spr_reg;
    logic       done_reg;

    logic [6:0] in_x;
    logic [5:0] in_y;
    logic [7:0] xp1;
    addr_t      base;

    assign in_x = in_data[6:0];
    assign in_y = in_data[12:7];
    assign xp1  = {1'b0, in_x} + 8'd1;
    assign base = row_base(in_y);

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            off_a_reg     <= base + addr_t'(in_x[6:1]);
            off_b_reg     <= base + addr_t'(xp1[7:1]);
            first_aux_reg <= ~in_x[0];
            nib_reg       <= in_y[0] ? NIB_HIGH : NIB_LOW;
            spr_reg       <= in_data[20:13];
            done_reg      <= in_last;
        end
    end

    // read issue
    addr_t      iss_addr;
    logic       iss_bank;
    logic [2:0] iss_bit;
    logic [7:0] iss_mask;
    logic       iss_last;

    assign iss_addr = (cmd.step[2] ? off_b_reg : off_a_reg) + addr_t'(cmd.step[1:0]);
    assign iss_bank = cmd.step[2] ? ~first_aux_reg : first_aux_reg;
    assign iss_bit  = ~{cmd.step[1:0], cmd.step[2]};
    assign iss_mask = spr_reg[iss_bit] ? nib_reg : 8'h00;
    assign iss_last = (cmd.step == LAST_STEP);

    // write-back stage
    logic       wb_valid_reg;
    logic       wb_bank_reg;
    addr_t      wb_addr_reg;
    logic [7:0] wb_mask_reg;
    logic       wb_last_reg;
    logic       wb_done_reg;
    logic       wb_advance;
    logic       wb_write;
    logic [7:0] aux_q_reg;
    logic [7:0] main_q_reg;
    logic [7:0] wb_new;

    assign wb_advance = !out_valid || out_ready;
    assign wb_write   = wb_valid_reg && wb_advance;
    assign wb_new     = (wb_bank_reg ? aux_q_reg : main_q_reg) ^ wb_mask_reg;

    assign status.wb_free  = !wb_valid_reg || wb_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wb_valid_reg <= 1'b0;
        else if (status.wb_free)
            wb_valid_reg <= cmd.issue;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            wb_bank_reg <= iss_bank;
            wb_addr_reg <= iss_addr;
            wb_mask_reg <= iss_mask;
            wb_last_reg <= iss_last;
            wb_done_reg <= iss_last & done_reg;
        end
    end

    // display banks
    logic [7:0] aux_mem  [BANK_DEPTH];
    logic [7:0] main_mem [BANK_DEPTH];
    addr_t      wr_addr;
    logic [7:0] wr_data;
    logic       aux_we;
    logic       main_we;

    assign wr_addr = cmd.clear_we ? cmd.clear_addr : wb_addr_reg;
    assign wr_data = cmd.clear_we ? 8'h00 : wb_new;
    assign aux_we  = cmd.clear_we || (wb_write && wb_bank_reg);
    assign main_we = cmd.clear_we || (wb_write && !wb_bank_reg);

    always_ff @(posedge clk)
    begin
        if (aux_we)
            aux_mem[wr_addr] <= wr_data;
        if (cmd.issue && iss_bank)
            aux_q_reg <= aux_mem[iss_addr];
    end

    always_ff @(posedge clk)
    begin
        if (main_we)
            main_mem[wr_addr] <= wr_data;
        if (cmd.issue && !iss_bank)
            main_q_reg <= main_mem[iss_addr];
    end

    // output register
    logic       out_valid_reg;
    logic       out_bank_reg;
    addr_t      out_addr_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (wb_advance)
            out_valid_reg <= wb_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wb_write)
        begin
            out_bank_reg <= wb_bank_reg;
            out_addr_reg <= wb_addr_reg;
            out_byte_reg <= wb_new;
            out_last_reg <= wb_last_reg;
            out_done_reg <= wb_done_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {5'b0, out_byte_reg, out_addr_reg, out_bank_reg};
    assign out_last  = out_last_reg;
    assign out_user  = out_done_reg;

endmodule

`default_nettype wire

### rtl/interleaved_lores_xor_sprite_row_blit_unit.sv
// top level of the interleaved double low-res xor sprite row blitter
// depends on ilxsb_pkg, ilxsb_ctrl and ilxsb_datapath
//
// usage:
//   slave stream: one beat per sprite row; tdata holds column, row and the
//   eight pixel bits, tlast marks the last row of a sprite
//   master stream: eight beats per row, one per byte written to display memory
//   (four in the bank of the first column, then four in the other bank);
//   tdata holds bank, byte offset and new byte, tlast marks the eighth beat,
//   tuser echoes the end-of-sprite flag on that beat
//   intake: a new row is accepted only after the eight byte steps of the
//   previous row through the single read-modify-write stage have drained
//   path: item registers, then the write-back stage, then the output register
//   reset: both 1024-byte banks are swept to zero, one offset per cycle in
//   both banks at once, so tready stays low until the sweep is done
//   stall: a held master beat holds the write-back stage and freezes the
//   byte sequence; no beat is dropped or repeated
`default_nettype none

module interleaved_lores_xor_sprite_row_blit_unit
    import ilxsb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // x_column[6:0], row_y[12:7], sprite_row[20:13]
    input  wire logic        s_axis_tlast,  // end_of_sprite
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // bank[0], byte_address[10:1], byte_data[18:11]
    output logic             m_axis_tlast,  // last_write
    output logic             m_axis_tuser   // sprite_done
);

    blit_cmd_t    cmd;
    blit_status_t status;

    // sequencer: clear sweep, row intake, byte step issue
    ilxsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // address math, banks, xor write-back and output beat register
    ilxsb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_data  (m_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_last  (m_axis_tlast),
        .out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire
